>>> hdl/sqe_pkg.sv
// Shared types and constants of the stack/queue engine.
`default_nettype none
package sqe_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int VAL_W       = 32;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
  localparam int SWAP_MIN    = 2;

  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_PRINT = 3'd1;
  localparam logic [2:0] OP_PEEK  = 3'd2;
  localparam logic [2:0] OP_POP   = 3'd3;
  localparam logic [2:0] OP_SWAP  = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_PEEK_EMPTY = 3'd1;
  localparam logic [2:0] ST_POP_EMPTY  = 3'd2;
  localparam logic [2:0] ST_SWAP_SHORT = 3'd3;
  localparam logic [2:0] ST_PUSH_FULL  = 3'd4;

  typedef struct packed {
    logic [2:0]              opcode;
    logic signed [VAL_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] data_out;
    logic [2:0]              status;
    logic                    has_data;
    logic                    last;
  } out_item_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_DN,
    CELL_SHIFT_UP,
    CELL_LOAD,
    CELL_SWAP,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] sel;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> hdl/sqe_cell.sv
// One storage cell of the element chain.
`default_nettype none
module sqe_cell
  import sqe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire cell_ctl_t        ctl,
  input  wire logic [VAL_W-1:0] prev_val,
  input  wire logic [VAL_W-1:0] next_val,
  input  wire logic [VAL_W-1:0] head_val,
  input  wire logic [VAL_W-1:0] push_val,
  output logic      [VAL_W-1:0] val
);

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      CELL_SHIFT_DN: val_nxt = prev_val;
      CELL_SHIFT_UP: val_nxt = next_val;
      CELL_LOAD: begin
        if (cell_idx == ctl.sel) val_nxt = push_val;
      end
      CELL_SWAP: begin
        if (cell_idx == IDX_W'(0)) begin
          val_nxt = next_val;
        end else if (cell_idx == IDX_W'(1)) begin
          val_nxt = prev_val;
        end
      end
      // the tail cell wraps the head around
      CELL_ROTATE: val_nxt = (cell_idx == ctl.sel) ? head_val : next_val;
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule
`default_nettype wire

>>> hdl/stack_queue_engine_unit.sv
// Push, pop, peek and swap give their result, registered, in the cycle after the input transfer.
// One such item per cycle while the output is not stalled; print-all of N elements sends them
// one element per cycle (while the output is not stalled) out of the head cell while the chain rotates by one.
// Reset (synchronous, active low) empties the store and selects stack mode;
// cell contents are undefined until written.
`default_nettype none
module stack_queue_engine_unit
  import sqe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_data
);

  typedef enum logic {
    S_IDLE,
    S_PRINT
  } state_t;

  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic               stack_mode_r;
  logic               out_valid_r;
  out_item_t          out_item_r, out_item_nxt;
  logic               out_load;
  logic               out_free;
  logic               accept;
  logic [COUNT_W-1:0] count_m1;
  cell_ctl_t          cell_ctl;
  logic [VAL_W-1:0]   cell_val [STORE_DEPTH];

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign count_m1  = count_r - COUNT_W'(1);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    rem_nxt      = rem_r;
    out_load     = 1'b0;
    out_item_nxt = '0;
    cell_ctl.op  = CELL_HOLD;
    cell_ctl.sel = '0;
    out_item_nxt.last = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.opcode)
            OP_PUSH: begin
              out_load = 1'b1;
              if (count_r == COUNT_W'(STORE_DEPTH)) begin
                out_item_nxt.status = ST_PUSH_FULL;
              end else begin
                cell_ctl.op  = stack_mode_r ? CELL_SHIFT_DN : CELL_LOAD;
                cell_ctl.sel = count_r[IDX_W-1:0];
                count_nxt    = count_r + COUNT_W'(1);
              end
            end
            OP_PRINT: begin
              if (count_r != '0) begin
                state_nxt = S_PRINT;
                rem_nxt   = count_r;
              end
            end
            OP_PEEK: begin
              out_load = 1'b1;
              if (count_r == '0) begin
                out_item_nxt.status = ST_PEEK_EMPTY;
              end else begin
                out_item_nxt.data_out = cell_val[0];
                out_item_nxt.has_data = 1'b1;
              end
            end
            OP_POP: begin
              out_load = 1'b1;
              if (count_r == '0) begin
                out_item_nxt.status = ST_POP_EMPTY;
              end else begin
                cell_ctl.op = CELL_SHIFT_UP;
                count_nxt   = count_m1;
              end
            end
            OP_SWAP: begin
              out_load = 1'b1;
              if (count_r < COUNT_W'(SWAP_MIN)) begin
                out_item_nxt.status = ST_SWAP_SHORT;
              end else begin
                cell_ctl.op = CELL_SWAP;
              end
            end
            default: begin
              // unknown opcode: drop, no result
            end
          endcase
        end
      end
      S_PRINT: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_item_nxt.data_out = cell_val[0];
          out_item_nxt.has_data = 1'b1;
          out_item_nxt.last     = (rem_r == COUNT_W'(1));
          cell_ctl.op           = CELL_ROTATE;
          cell_ctl.sel          = count_m1[IDX_W-1:0];
          rem_nxt               = rem_r - COUNT_W'(1);
          if (rem_r == COUNT_W'(1)) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      rem_r        <= '0;
      stack_mode_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      if (cfg_valid && cfg_ready) stack_mode_r <= cfg_data;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (out_load) out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
    logic [VAL_W-1:0] prev_val;
    logic [VAL_W-1:0] next_val;

    if (g == 0) begin : g_first
      assign prev_val = in_data.push_value;
    end else begin : g_mid
      assign prev_val = cell_val[g-1];
    end

    if (g == STORE_DEPTH - 1) begin : g_last
      assign next_val = cell_val[0];
    end else begin : g_inner
      assign next_val = cell_val[g+1];
    end

    sqe_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(g)),
      .ctl      (cell_ctl),
      .prev_val (prev_val),
      .next_val (next_val),
      .head_val (cell_val[0]),
      .push_val (in_data.push_value),
      .val      (cell_val[g])
    );
  end

endmodule
`default_nettype wire
